// ===== hw/rtl/pid_deadband_int_separation_unit_defines.svh =====
// Assertion macros for the PID dead band / integral separation unit.
`ifndef PID_DEADBAND_INT_SEPARATION_UNIT_DEFINES_SVH
`define PID_DEADBAND_INT_SEPARATION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PDIS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PDIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pdis_pkg.sv =====
// Shared types, widths and register indexes for the PID dead band / integral separation unit.
package pdis_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 8;

    localparam int GAIN_W   = 16;
    localparam int DRIVE_W  = 16;
    localparam int LIMIT_W  = 15;
    localparam int THRESH_W = 16;

    localparam int ERR_W   = SAMPLE_WIDTH + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int MAG_W   = (ERR_W > THRESH_W) ? ERR_W : THRESH_W;
    localparam int PROD_W  = GAIN_W + ERR_W;
    localparam int DPROD_W = GAIN_W + DIFF_W;
    localparam int ACC_W   = LIMIT_W + GAIN_FRAC_BITS + 1;
    localparam int ACCS_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
    localparam int SUM_W   = ((DPROD_W > ACCS_W) ? DPROD_W : ACCS_W) + 2;
    localparam int HALF    = (2 ** GAIN_FRAC_BITS) / 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P          = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I          = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D          = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_LIMIT       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEGRAL_LIMIT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_BAND       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEGRAL_WINDOW = 3'd6;

    localparam logic REQ_STEP  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic                           req_type;
        logic signed [SAMPLE_WIDTH-1:0] setpoint;
        logic signed [SAMPLE_WIDTH-1:0] measurement;
    } in_item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
    } out_item_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIMIT_W-1:0]       out_limit;
        logic [LIMIT_W-1:0]       integral_limit;
        logic [THRESH_W-1:0]      dead_band;
        logic [THRESH_W-1:0]      integral_window;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] prior_error;
        logic signed [ACC_W-1:0] integral_acc;
    } pdis_state_t;

endpackage

// ===== hw/rtl/pdis_core.sv =====
// One PID control step (error, dead band, windowed integral, P/I/D sum, output clamp and rounding) or a clear request.
module pdis_core (
    input  pdis_pkg::in_item_t    item,
    input  pdis_pkg::cfg_t        cfg,
    input  pdis_pkg::pdis_state_t state,
    output pdis_pkg::out_item_t   result,
    output pdis_pkg::pdis_state_t state_next
);
    import pdis_pkg::*;

    logic signed [ERR_W-1:0]   err;
    logic [ERR_W-1:0]          err_mag;
    logic signed [ERR_W-1:0]   err_db;
    logic [ERR_W-1:0]          db_mag;
    logic                      in_window;
    logic signed [PROD_W-1:0]  prod_p;
    logic signed [PROD_W-1:0]  prod_i;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DPROD_W-1:0] prod_d;
    logic signed [ACCS_W-1:0]  acc_sum;
    logic signed [ACCS_W-1:0]  ilim;
    logic signed [ACCS_W-1:0]  acc_clip;
    logic signed [ACC_W-1:0]   acc_new;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   olim;
    logic signed [SUM_W-1:0]   rounded;
    logic signed [SUM_W-1:0]   scaled;
    logic signed [DRIVE_W-1:0] limit_pos;

    assign err     = ERR_W'(item.setpoint) - ERR_W'(item.measurement);
    assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign err_db  = (MAG_W'(err_mag) < MAG_W'(cfg.dead_band)) ? '0 : err;
    assign db_mag  = err_db[ERR_W-1] ? ERR_W'(-err_db) : ERR_W'(err_db);
    assign in_window = MAG_W'(db_mag) < MAG_W'(cfg.integral_window);

    assign prod_p = PROD_W'(cfg.gain_p) * PROD_W'(err_db);
    assign prod_i = PROD_W'(cfg.gain_i) * PROD_W'(err_db);
    assign diff   = DIFF_W'(err_db) - DIFF_W'(state.prior_error);
    assign prod_d = DPROD_W'(cfg.gain_d) * DPROD_W'(diff);

    // integral clamp to +-integral_limit in Q.F units
    assign acc_sum = ACCS_W'(state.integral_acc) + ACCS_W'(prod_i);
    assign ilim    = $signed(ACCS_W'(cfg.integral_limit) << GAIN_FRAC_BITS);

    always_comb
    begin
        if (acc_sum > ilim)
        begin
            acc_clip = ilim;
        end
        else if (acc_sum < -ilim)
        begin
            acc_clip = -ilim;
        end
        else
        begin
            acc_clip = acc_sum;
        end
    end

    assign acc_new = in_window ? ACC_W'(acc_clip) : state.integral_acc;

    assign sum       = SUM_W'(prod_p) + SUM_W'(acc_new) + SUM_W'(prod_d);
    assign olim      = $signed(SUM_W'(cfg.out_limit) << GAIN_FRAC_BITS);
    assign rounded   = sum + SUM_W'(HALF);
    assign scaled    = rounded >>> GAIN_FRAC_BITS;
    assign limit_pos = $signed(DRIVE_W'(cfg.out_limit));

    always_comb
    begin
        if (item.req_type == REQ_CLEAR)
        begin
            result.drive           = '0;
            result.clamped         = 1'b0;
            state_next.prior_error  = '0;
            state_next.integral_acc = '0;
        end
        else
        begin
            state_next.prior_error  = err_db;
            state_next.integral_acc = acc_new;
            if (sum > olim)
            begin
                result.drive   = limit_pos;
                result.clamped = 1'b1;
            end
            else if (sum < -olim)
            begin
                result.drive   = -limit_pos;
                result.clamped = 1'b1;
            end
            else
            begin
                result.drive   = scaled[DRIVE_W-1:0];
                result.clamped = 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/pid_deadband_int_separation_unit.sv =====
// Top level of the PID dead band / integral separation unit: registers, handshakes, config.
// Path: an accepted item enters the input register, then the result register once that stage is free.
// Throughput: one item per cycle unless out_ready stalls; stored error and integral update in the same step.
// The input stage keeps accepting while a result waits, until both stages are full.
// Reset (rst_n low, async): stages empty, state zero, gains and dead band zero, limits and window all ones.
module pid_deadband_int_separation_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pdis_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pdis_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [pdis_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pdis_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pdis_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_item_reg;
    pdis_state_t state_reg;
    pdis_state_t state_next;
    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    out_item_t   step_result;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_GAIN_P:          cfg_next.gain_p          = $signed(cfg_data);
                REG_GAIN_I:          cfg_next.gain_i          = $signed(cfg_data);
                REG_GAIN_D:          cfg_next.gain_d          = $signed(cfg_data);
                REG_OUT_LIMIT:       cfg_next.out_limit       = cfg_data[LIMIT_W-1:0];
                REG_INTEGRAL_LIMIT:  cfg_next.integral_limit  = cfg_data[LIMIT_W-1:0];
                REG_DEAD_BAND:       cfg_next.dead_band       = cfg_data[THRESH_W-1:0];
                REG_INTEGRAL_WINDOW: cfg_next.integral_window = cfg_data[THRESH_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    pdis_core u_core (
        .item       (in_item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .result     (step_result),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg              <= '0;
            cfg_reg.gain_p          <= '0;
            cfg_reg.gain_i          <= '0;
            cfg_reg.gain_d          <= '0;
            cfg_reg.out_limit       <= '1;
            cfg_reg.integral_limit  <= '1;
            cfg_reg.dead_band       <= '0;
            cfg_reg.integral_window <= '1;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== hw/rtl/pdis_checker.sv =====
// Port-level checks for the PID dead band / integral separation unit, bound to the top level.
`include "pid_deadband_int_separation_unit_defines.svh"

module pdis_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input pdis_pkg::in_item_t  in_item,
    input logic                out_valid,
    input logic                out_ready,
    input pdis_pkg::out_item_t out_item
);
    import pdis_pkg::*;

    `PDIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result item changed or dropped while stalled")
    `PDIS_ASSERT_NOW(a_stall_only_when_full, !in_ready, out_valid, "input stalled with result stage empty")
    `PDIS_ASSERT_NEXT(a_result_follows, in_valid && in_ready && !out_valid, ##1 out_valid, "accepted item produced no result in two cycles")
    `PDIS_ASSERT_NOW(a_drive_symmetric, out_valid, out_item.drive != {1'b1, {(DRIVE_W-1){1'b0}}}, "drive outside symmetric range")

endmodule

bind pid_deadband_int_separation_unit pdis_checker u_pdis_checker (.*);

// ===== tb/pid_deadband_int_separation_unit_checker.sv =====
// Checker for the PID unit: tracks register writes, predicts each drive result and compares.
module pid_deadband_int_separation_unit_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  pdis_pkg::in_item_t              in_item,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  pdis_pkg::out_item_t             out_item,
    input  logic                            cfg_we,
    input  logic [pdis_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pdis_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import pdis_pkg::*;

    cfg_t                    settings;
    logic signed [ERR_W-1:0] last_error;
    logic signed [ACC_W-1:0] integral;
    out_item_t               drive_q[$];

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic out_item_t pid_step(in_item_t it);
        out_item_t r;
        longint    err;
        longint    acc;
        longint    ilim;
        longint    olim;
        longint    total;
        longint    d;
        r = '0;
        if (it.req_type == REQ_CLEAR)
        begin
            last_error = '0;
            integral = '0;
            return r;
        end
        err = longint'($signed(it.setpoint)) - longint'($signed(it.measurement));
        if (magnitude(err) < longint'(settings.dead_band))
            err = 0;
        acc = longint'(integral);
        if (magnitude(err) < longint'(settings.integral_window))
        begin
            ilim = longint'(settings.integral_limit) <<< GAIN_FRAC_BITS;
            acc = acc + longint'($signed(settings.gain_i)) * err;
            if (acc > ilim)
                acc = ilim;
            else if (acc < -ilim)
                acc = -ilim;
        end
        total = longint'($signed(settings.gain_p)) * err + acc
              + longint'($signed(settings.gain_d)) * (err - longint'(last_error));
        integral = ACC_W'(acc);
        last_error = ERR_W'(err);
        olim = longint'(settings.out_limit) <<< GAIN_FRAC_BITS;
        if (total > olim)
        begin
            d = longint'(settings.out_limit);
            r.clamped = 1'b1;
        end
        else if (total < -olim)
        begin
            d = -longint'(settings.out_limit);
            r.clamped = 1'b1;
        end
        else
        begin
            d = (total + HALF) >>> GAIN_FRAC_BITS;
        end
        r.drive = DRIVE_W'(d);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            settings.gain_p = '0;
            settings.gain_i = '0;
            settings.gain_d = '0;
            settings.out_limit = '1;
            settings.integral_limit = '1;
            settings.dead_band = '0;
            settings.integral_window = '1;
            last_error = '0;
            integral = '0;
            drive_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (drive_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected item: expected none, actual drive %0d clamped %0b",
                             $time, out_item.drive, out_item.clamped);
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (out_item.drive !== want.drive)
                    begin
                        fail_count++;
                        $display("%0t: drive mismatch: expected %0d, actual %0d",
                                 $time, want.drive, out_item.drive);
                    end
                    if (out_item.clamped !== want.clamped)
                    begin
                        fail_count++;
                        $display("%0t: clamped mismatch: expected %0b, actual %0b",
                                 $time, want.clamped, out_item.clamped);
                    end
                end
            end
            if (in_valid && in_ready)
                drive_q.push_back(pid_step(in_item));
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_GAIN_P:          settings.gain_p = cfg_data;
                    REG_GAIN_I:          settings.gain_i = cfg_data;
                    REG_GAIN_D:          settings.gain_d = cfg_data;
                    REG_OUT_LIMIT:       settings.out_limit = cfg_data[LIMIT_W-1:0];
                    REG_INTEGRAL_LIMIT:  settings.integral_limit = cfg_data[LIMIT_W-1:0];
                    REG_DEAD_BAND:       settings.dead_band = cfg_data;
                    REG_INTEGRAL_WINDOW: settings.integral_window = cfg_data;
                    default:             ;
                endcase
            end
            pending = drive_q.size();
        end
    end

endmodule

// ===== tb/pid_deadband_int_separation_unit_tb.sv =====
// Testbench top for the PID unit: clock, reset, register setup, sample stimulus and verdict.
module pid_deadband_int_separation_unit_tb;

    import pdis_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count;
    int pending;

    pid_deadband_int_separation_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    pid_deadband_int_separation_unit_checker drive_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // leaves in_valid high at the negedge after acceptance; caller lowers or reloads it
    task automatic offer(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic sample(input logic req, input int sp, input int ms);
        in_item_t it;
        it.req_type = req;
        it.setpoint = SAMPLE_WIDTH'(sp);
        it.measurement = SAMPLE_WIDTH'(ms);
        offer(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic load_settings(input cfg_t c);
        wait_idle();
        write_reg(REG_GAIN_P, c.gain_p);
        write_reg(REG_GAIN_I, c.gain_i);
        write_reg(REG_GAIN_D, c.gain_d);
        write_reg(REG_OUT_LIMIT, {1'($urandom_range(1)), c.out_limit});
        write_reg(REG_INTEGRAL_LIMIT, {1'($urandom_range(1)), c.integral_limit});
        write_reg(REG_DEAD_BAND, c.dead_band);
        write_reg(REG_INTEGRAL_WINDOW, c.integral_window);
        write_reg(REG_SPARE, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(4))
            0:       return '0;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return GAIN_W'(int'($urandom_range(1023)) - 512);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return LIMIT_W'($urandom_range(2000));
            default: return LIMIT_W'($urandom);
        endcase
    endfunction

    function automatic logic [THRESH_W-1:0] pick_thresh();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return THRESH_W'($urandom_range(400));
            default: return THRESH_W'($urandom);
        endcase
    endfunction

    function automatic cfg_t random_settings(input int k);
        cfg_t c;
        if (k == 0)
        begin
            c.gain_p = 16'h7FFF;
            c.gain_i = 16'h7FFF;
            c.gain_d = 16'h7FFF;
            c.out_limit = '1;
            c.integral_limit = '1;
            c.dead_band = '0;
            c.integral_window = '1;
        end
        else if (k == 1)
        begin
            c.gain_p = 16'h8000;
            c.gain_i = 16'h8000;
            c.gain_d = 16'h8000;
            c.out_limit = '0;
            c.integral_limit = '0;
            c.dead_band = '1;
            c.integral_window = '0;
        end
        else
        begin
            c.gain_p = pick_gain();
            c.gain_i = pick_gain();
            c.gain_d = pick_gain();
            c.out_limit = pick_limit();
            c.integral_limit = pick_limit();
            c.dead_band = pick_thresh();
            c.integral_window = pick_thresh();
        end
        return c;
    endfunction

    // mostly samples near the setpoint so dead band and window edges get hit
    function automatic in_item_t random_item();
        in_item_t it;
        int       sp;
        int       ms;
        int       spread;
        it.req_type = ($urandom_range(99) < 4) ? REQ_CLEAR : REQ_STEP;
        sp = int'($urandom_range(65535)) - 32768;
        ms = int'($urandom_range(65535)) - 32768;
        if ($urandom_range(99) >= 35)
        begin
            case ($urandom_range(2))
                0:       spread = 8;
                1:       spread = 300;
                default: spread = 3000;
            endcase
            ms = sp - (int'($urandom_range(2 * spread)) - spread);
            if (ms > 32767)
                ms = 32767;
            else if (ms < -32768)
                ms = -32768;
        end
        it.setpoint = SAMPLE_WIDTH'(sp);
        it.measurement = SAMPLE_WIDTH'(ms);
        return it;
    endfunction

    initial
    begin
        cfg_t c;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 59;

        // reset settings
        sample(REQ_STEP, 32767, -32768);
        sample(REQ_STEP, -32768, 32767);

        c.gain_p = 16'h0100;
        c.gain_i = 16'h0080;
        c.gain_d = 16'h0040;
        c.out_limit = '1;
        c.integral_limit = 15'd1000;
        c.dead_band = '0;
        c.integral_window = '1;
        load_settings(c);
        sample(REQ_STEP, 32767, -32768);
        sample(REQ_STEP, -32768, 32767);
        sample(REQ_STEP, 0, 0);
        sample(REQ_STEP, 100, 0);
        sample(REQ_STEP, -100, 7);
        sample(REQ_CLEAR, 1234, -5);
        sample(REQ_STEP, 300, 0);

        // sum landing exactly on the output limit
        c.gain_i = '0;
        c.gain_d = '0;
        c.out_limit = 15'd100;
        c.integral_limit = '0;
        load_settings(c);
        sample(REQ_CLEAR, 0, 0);
        sample(REQ_STEP, 100, 0);
        sample(REQ_STEP, 101, 0);
        sample(REQ_STEP, 0, 100);
        sample(REQ_STEP, 0, 101);

        // integral separation: hold outside window, no re-clamp until back inside
        c.gain_p = '0;
        c.gain_i = 16'h0100;
        c.out_limit = '1;
        c.integral_limit = '1;
        c.dead_band = 16'd10;
        c.integral_window = 16'd1000;
        load_settings(c);
        repeat (4) sample(REQ_STEP, 500, 0);
        sample(REQ_STEP, 5, 0);
        c.integral_limit = 15'd100;
        load_settings(c);
        sample(REQ_STEP, 2000, 0);
        sample(REQ_STEP, 0, 0);
        c.integral_window = '0;
        load_settings(c);
        sample(REQ_STEP, 0, 0);
        sample(REQ_STEP, 300, 0);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 13 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                load_settings(random_settings(phase * 4 + seg));
                repeat (130) offer(random_item());
            end
        end

        wait_idle();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("pid_deadband_int_separation_unit_tb: done, clean");
        else
            $display("pid_deadband_int_separation_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        #400000;
        $display("pid_deadband_int_separation_unit_tb: done, errors");
        $finish;
    end

endmodule

// ===== pid_deadband_int_separation_unit.f =====
+incdir+hw/rtl
hw/rtl/pdis_pkg.sv
hw/rtl/pdis_core.sv
hw/rtl/pid_deadband_int_separation_unit.sv
hw/rtl/pdis_checker.sv
tb/pid_deadband_int_separation_unit_checker.sv
tb/pid_deadband_int_separation_unit_tb.sv
